// ===== sv/stq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the stack-to-queue transfer engine.
// No dependencies; compile first.
package stq_pkg;

    localparam int DEPTH_DEFAULT     = 64;
    localparam int WORD_BITS_DEFAULT = 32;
    localparam int ACTION_BITS       = 3;
    localparam int ITEM_BITS         = 32;
    localparam int OUT_BITS          = 32;
    localparam int STATUS_BITS       = 2;
    localparam int QCOUNT_BITS       = 7;

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_ENQ  = 3'd0,
        ACT_DEQ  = 3'd1,
        ACT_PUSH = 3'd2,
        ACT_POP  = 3'd3,
        ACT_XFER = 3'd4,
        ACT_DUMP = 3'd5
    } t_action;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_XFER,
        S_DUMP
    } t_state;

    typedef enum logic [1:0] {
        OSEL_ZERO,
        OSEL_STACK,
        OSEL_QUEUE
    } t_out_sel;

    typedef struct packed {
        logic     q_wr;
        logic     q_src_stack;
        logic     q_deq;
        logic     q_rd;
        logic     idx_clr;
        logic     s_push;
        logic     s_pop;
        logic     out_load;
        t_out_sel out_sel;
        t_status  out_status;
        logic     out_last;
    } t_cmd;

    typedef struct packed {
        logic q_full;
        logic q_empty;
        logic s_full;
        logic s_empty;
        logic dump_more;
        logic dump_last;
        logic out_free;
    } t_stat;

endpackage

// ===== sv/stq_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and results.
// Depends on stq_pkg.
interface stq_req_if import stq_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [ACTION_BITS-1:0] action;
    logic [ITEM_BITS-1:0]   item_value;

    modport source (output valid, output action, output item_value, input ready);
    modport sink   (input valid, input action, input item_value, output ready);
endinterface

interface stq_rsp_if import stq_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [OUT_BITS-1:0]    out_value;
    logic [STATUS_BITS-1:0] status;
    logic                   last_of_run;
    logic [QCOUNT_BITS-1:0] queue_count;

    modport source (output valid, output out_value, output status, output last_of_run,
                    output queue_count, input ready);
    modport sink   (input valid, input out_value, input status, input last_of_run,
                    input queue_count, output ready);
endinterface

// ===== sv/stq_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: circular queue memory, stack memory, pointers and result register.
// Depends on stq_pkg; driven by stq_ctrl commands.
module stq_datapath import stq_pkg::*; #(
    parameter int DEPTH     = DEPTH_DEFAULT,
    parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    input  logic [ITEM_BITS-1:0]   i_item_value,
    input  logic                   i_out_ready,
    output t_stat                  o_stat,
    output logic                   o_out_valid,
    output logic [OUT_BITS-1:0]    o_out_value,
    output logic [STATUS_BITS-1:0] o_out_status,
    output logic                   o_out_last,
    output logic [QCOUNT_BITS-1:0] o_out_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int XB    = (WORD_BITS > ITEM_BITS) ? WORD_BITS :
                           ((OUT_BITS > ITEM_BITS) ? OUT_BITS : ITEM_BITS);

    logic [WORD_BITS-1:0]   r_qmem [DEPTH];
    logic [WORD_BITS-1:0]   r_smem [DEPTH];

    logic [PTR_W-1:0]       r_head, n_head;
    logic [CNT_W-1:0]       r_qfill, n_qfill;
    logic [CNT_W-1:0]       r_sfill, n_sfill;
    logic [CNT_W-1:0]       r_idx, n_idx;
    logic [WORD_BITS-1:0]   r_q_rd;
    logic [WORD_BITS-1:0]   r_s_rd;
    logic                   r_out_valid, n_out_valid;
    logic [OUT_BITS-1:0]    r_out_value, n_out_value;
    t_status                r_out_status;
    logic                   r_out_last;
    logic [QCOUNT_BITS-1:0] r_out_count;

    logic [CNT_W:0]         tail_sum, tail_wrap, rd_sum, rd_wrap;
    logic [PTR_W-1:0]       q_waddr, q_raddr, s_waddr, s_raddr;
    logic [XB-1:0]          item_ext, out_ext;
    logic [WORD_BITS-1:0]   item_word, q_wdata, sel_word;
    logic                   q_full, q_empty, s_full, s_empty;
    logic                   q_we, q_deq_ok, s_we, s_re;

    always_comb begin
        q_full  = (r_qfill == CNT_W'(DEPTH));
        q_empty = (r_qfill == '0);
        s_full  = (r_sfill == CNT_W'(DEPTH));
        s_empty = (r_sfill == '0);

        tail_sum  = (CNT_W+1)'(r_head) + (CNT_W+1)'(r_qfill);
        tail_wrap = (tail_sum >= (CNT_W+1)'(DEPTH)) ? tail_sum - (CNT_W+1)'(DEPTH) : tail_sum;
        q_waddr   = tail_wrap[PTR_W-1:0];
        rd_sum    = (CNT_W+1)'(r_head) + (CNT_W+1)'(r_idx);
        rd_wrap   = (rd_sum >= (CNT_W+1)'(DEPTH)) ? rd_sum - (CNT_W+1)'(DEPTH) : rd_sum;
        q_raddr   = rd_wrap[PTR_W-1:0];

        s_waddr   = r_sfill[PTR_W-1:0];
        s_raddr   = PTR_W'(r_sfill - CNT_W'(1));

        item_ext  = XB'(i_item_value);
        item_word = item_ext[WORD_BITS-1:0];
        q_wdata   = i_cmd.q_src_stack ? r_s_rd : item_word;

        q_we      = i_cmd.q_wr && !q_full;
        q_deq_ok  = i_cmd.q_deq && !q_empty;
        s_we      = i_cmd.s_push && !s_full;
        s_re      = i_cmd.s_pop && !s_empty;

        n_qfill   = r_qfill + CNT_W'(q_we) - CNT_W'(q_deq_ok);
        n_head    = r_head;
        if (q_deq_ok) begin
            n_head = (r_head == PTR_W'(DEPTH - 1)) ? '0 : r_head + PTR_W'(1);
        end

        n_sfill = r_sfill;
        if (s_we) begin
            n_sfill = r_sfill + CNT_W'(1);
        end else if (s_re) begin
            n_sfill = r_sfill - CNT_W'(1);
        end

        n_idx = r_idx;
        if (i_cmd.idx_clr) begin
            n_idx = '0;
        end else if (i_cmd.q_rd) begin
            n_idx = r_idx + CNT_W'(1);
        end

        unique case (i_cmd.out_sel)
            OSEL_STACK: sel_word = r_s_rd;
            OSEL_QUEUE: sel_word = r_q_rd;
            default:    sel_word = '0;
        endcase
        out_ext     = XB'(sel_word);
        n_out_value = out_ext[OUT_BITS-1:0];

        n_out_valid = r_out_valid;
        if (i_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        o_stat.q_full    = q_full;
        o_stat.q_empty   = q_empty;
        o_stat.s_full    = s_full;
        o_stat.s_empty   = s_empty;
        o_stat.dump_more = (r_idx < r_qfill);
        o_stat.dump_last = ((r_idx + CNT_W'(1)) == r_qfill);
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            r_qmem[q_waddr] <= q_wdata;
        end
        if (i_cmd.q_rd) begin
            r_q_rd <= r_qmem[q_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_smem[s_waddr] <= item_word;
        end
        if (s_re) begin
            r_s_rd <= r_smem[s_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_qfill     <= '0;
            r_sfill     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_qfill     <= n_qfill;
            r_sfill     <= n_sfill;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_value  <= n_out_value;
            r_out_status <= i_cmd.out_status;
            r_out_last   <= i_cmd.out_last;
            r_out_count  <= QCOUNT_BITS'(n_qfill);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_value  = r_out_value;
    assign o_out_status = r_out_status;
    assign o_out_last   = r_out_last;
    assign o_out_count  = r_out_count;

endmodule

// ===== sv/stq_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: decodes each request and sequences pop, transfer and dump.
// Depends on stq_pkg; commands stq_datapath.
module stq_ctrl import stq_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic [ACTION_BITS-1:0] i_action,
    input  t_stat                  i_stat,
    output logic                   o_in_ready,
    output t_cmd                   o_cmd
);

    t_state r_state, n_state;
    logic   r_pend, n_pend;
    logic   r_pend_last, n_pend_last;
    logic   r_drop, n_drop;
    logic   accept, load, issue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
            r_drop      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_pend_last <= n_pend_last;
            r_drop      <= n_drop;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_pend      = r_pend;
        n_pend_last = r_pend_last;
        n_drop      = r_drop;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        accept      = 1'b0;
        load        = 1'b0;
        issue       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = i_stat.out_free;
                accept     = i_in_valid && i_stat.out_free;
                if (accept) begin
                    o_cmd.out_sel    = OSEL_ZERO;
                    o_cmd.out_status = ST_OK;
                    o_cmd.out_last   = 1'b1;
                    unique case (t_action'(i_action))
                        ACT_ENQ: begin
                            o_cmd.out_load = 1'b1;
                            if (i_stat.q_full) begin
                                o_cmd.out_status = ST_FULL;
                            end else begin
                                o_cmd.q_wr = 1'b1;
                            end
                        end
                        ACT_DEQ: begin
                            o_cmd.out_load = 1'b1;
                            if (i_stat.q_empty) begin
                                o_cmd.out_status = ST_EMPTY;
                            end else begin
                                o_cmd.q_deq = 1'b1;
                            end
                        end
                        ACT_PUSH: begin
                            o_cmd.out_load = 1'b1;
                            if (i_stat.s_full) begin
                                o_cmd.out_status = ST_FULL;
                            end else begin
                                o_cmd.s_push = 1'b1;
                            end
                        end
                        ACT_POP: begin
                            if (i_stat.s_empty) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_status = ST_EMPTY;
                            end else begin
                                o_cmd.s_pop = 1'b1;
                                n_state     = S_POP;
                            end
                        end
                        ACT_XFER: begin
                            n_drop  = 1'b0;
                            n_pend  = 1'b0;
                            n_state = S_XFER;
                        end
                        ACT_DUMP: begin
                            if (i_stat.q_empty) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_status = ST_EMPTY;
                            end else begin
                                o_cmd.idx_clr = 1'b1;
                                n_pend        = 1'b0;
                                n_state       = S_DUMP;
                            end
                        end
                        default: begin
                            o_cmd.out_load = 1'b1;
                        end
                    endcase
                end
            end
            S_POP: begin
                o_cmd.out_load   = 1'b1;
                o_cmd.out_sel    = OSEL_STACK;
                o_cmd.out_status = ST_OK;
                o_cmd.out_last   = 1'b1;
                n_state          = S_IDLE;
            end
            S_XFER: begin
                if (r_pend) begin
                    o_cmd.q_wr        = 1'b1;
                    o_cmd.q_src_stack = 1'b1;
                    if (i_stat.q_full) begin
                        n_drop = 1'b1;
                    end
                end
                if (!i_stat.s_empty) begin
                    o_cmd.s_pop = 1'b1;
                    n_pend      = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        o_cmd.out_load   = 1'b1;
                        o_cmd.out_sel    = OSEL_ZERO;
                        o_cmd.out_status = r_drop ? ST_FULL : ST_OK;
                        o_cmd.out_last   = 1'b1;
                        n_state          = S_IDLE;
                    end
                end
            end
            S_DUMP: begin
                load  = r_pend && i_stat.out_free;
                issue = i_stat.dump_more && (!r_pend || load);
                if (load) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_sel    = OSEL_QUEUE;
                    o_cmd.out_status = ST_OK;
                    o_cmd.out_last   = r_pend_last;
                    n_pend           = 1'b0;
                    if (r_pend_last) begin
                        n_state = S_IDLE;
                    end
                end
                if (issue) begin
                    o_cmd.q_rd  = 1'b1;
                    n_pend      = 1'b1;
                    n_pend_last = i_stat.dump_last;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/stack_to_queue_transfer_engine.sv =====
`timescale 1ns / 1ps
// Stack-to-queue transfer engine: a FIFO queue and a LIFO stack of words.
// Channels: i_req (action, item_value) in, o_rsp (out_value, status,
// last_of_run, queue_count) out, both valid/ready; a request is taken at a
// clock edge with valid and ready high.
// Enqueue, dequeue, push and unused codes: result registered at the edge that
// takes the request. Pop: result loaded from the registered stack read.
// Transfer: one stack read and one queue write per word, then one result.
// Dump: one result per word, each queue word first read into a register;
// an empty queue gives a single result with empty status.
// A new request is taken only when the controller is idle and the result
// register is empty or being emptied in the same cycle.
// Reset (i_rst_n low, synchronous) empties queue and stack and drops any
// pending result. The memories are not cleared; no clearing pass is needed.
// A stalled receiver holds o_rsp stable; a dump pauses word by word.
// Depends on stq_pkg, stq_if, stq_ctrl and stq_datapath.
module stack_to_queue_transfer_engine import stq_pkg::*; #(
    parameter int DEPTH     = DEPTH_DEFAULT,
    parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
    input logic        i_clk,
    input logic        i_rst_n,
    stq_req_if.sink    i_req,
    stq_rsp_if.source  o_rsp
);

    t_cmd  cmd;
    t_stat stat;

    stq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_action   (i_req.action),
        .i_stat     (stat),
        .o_in_ready (i_req.ready),
        .o_cmd      (cmd)
    );

    stq_datapath #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_item_value (i_req.item_value),
        .i_out_ready  (o_rsp.ready),
        .o_stat       (stat),
        .o_out_valid  (o_rsp.valid),
        .o_out_value  (o_rsp.out_value),
        .o_out_status (o_rsp.status),
        .o_out_last   (o_rsp.last_of_run),
        .o_out_count  (o_rsp.queue_count)
    );

endmodule

// ===== sv/stq_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the stack-to-queue transfer engine, bound to the top.
// Depends on stq_pkg and stack_to_queue_transfer_engine.
module stq_port_checks import stq_pkg::*; #(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [OUT_BITS-1:0]    i_out_value,
    input logic [STATUS_BITS-1:0] i_status,
    input logic                   i_last,
    input logic [QCOUNT_BITS-1:0] i_count
);

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_count <= QCOUNT_BITS'(DEPTH)))
        else $error("queue count beyond depth");

    a_mid_dump_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_last) |-> (i_status == ST_OK))
        else $error("non-final result without ok status");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status == ST_FULL || i_status == ST_EMPTY)) |->
        (i_out_value == '0 && i_last))
        else $error("rejected request carried data");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result withdrawn under stall");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> ($stable(i_out_value) && $stable(i_count)))
        else $error("result changed under stall");

endmodule

bind stack_to_queue_transfer_engine stq_port_checks #(
    .DEPTH (DEPTH)
) u_stq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_value (o_rsp.out_value),
    .i_status    (o_rsp.status),
    .i_last      (o_rsp.last_of_run),
    .i_count     (o_rsp.queue_count)
);

// ===== test/stq_checker.sv =====
`timescale 1ns / 1ps
// Checker for the stack-to-queue transfer engine: watches both channels, predicts
// every result from its own copy of queue and stack, and compares field by field.
// Depends on stq_pkg and stq_if.
module stq_checker import stq_pkg::*; #(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic i_clk,
    input  logic i_rst_n,
    stq_req_if   i_req,
    stq_rsp_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_result_count
);

    typedef struct {
        logic [OUT_BITS-1:0]    out_value;
        t_status                status;
        logic                   last_of_run;
        logic [QCOUNT_BITS-1:0] queue_count;
    } t_result;

    t_result             expected_results[$];
    logic [OUT_BITS-1:0] queue_words[DEPTH];
    logic [OUT_BITS-1:0] stack_words[DEPTH];
    int                  queue_head;
    int                  queue_fill;
    int                  stack_fill;

    function automatic void expect_result(logic [OUT_BITS-1:0] value, t_status st,
                                          logic last);
        t_result r;
        r.out_value   = value;
        r.status      = st;
        r.last_of_run = last;
        r.queue_count = QCOUNT_BITS'(queue_fill);
        expected_results.push_back(r);
    endfunction

    function automatic logic enqueue_word(logic [OUT_BITS-1:0] word);
        if (queue_fill >= DEPTH) begin
            return 1'b0;
        end
        queue_words[(queue_head + queue_fill) % DEPTH] = word;
        queue_fill++;
        return 1'b1;
    endfunction

    function automatic void predict_request(logic [ACTION_BITS-1:0] act,
                                            logic [ITEM_BITS-1:0] word);
        t_status             st;
        logic [OUT_BITS-1:0] value;
        int                  i;
        st    = ST_OK;
        value = '0;
        case (act)
            ACT_ENQ: begin
                if (!enqueue_word(word)) st = ST_FULL;
            end
            ACT_DEQ: begin
                if (queue_fill == 0) begin
                    st = ST_EMPTY;
                end else begin
                    queue_head = (queue_head + 1) % DEPTH;
                    queue_fill--;
                end
            end
            ACT_PUSH: begin
                if (stack_fill >= DEPTH) begin
                    st = ST_FULL;
                end else begin
                    stack_words[stack_fill] = word;
                    stack_fill++;
                end
            end
            ACT_POP: begin
                if (stack_fill == 0) begin
                    st = ST_EMPTY;
                end else begin
                    stack_fill--;
                    value = stack_words[stack_fill];
                end
            end
            ACT_XFER: begin
                while (stack_fill > 0) begin
                    stack_fill--;
                    if (!enqueue_word(stack_words[stack_fill])) st = ST_FULL;
                end
            end
            ACT_DUMP: begin
                if (queue_fill == 0) begin
                    st = ST_EMPTY;
                end else begin
                    for (i = 0; i < queue_fill; i++) begin
                        expect_result(queue_words[(queue_head + i) % DEPTH], ST_OK,
                                      i == queue_fill - 1);
                    end
                    return;
                end
            end
            default: ;
        endcase
        expect_result(value, st, 1'b1);
    endfunction

    function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            expected_results.delete();
            queue_head = 0;
            queue_fill = 0;
            stack_fill = 0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                o_result_count++;
                if (expected_results.size() == 0) begin
                    $error("unexpected result: out_value 0x%0h status %0d",
                           i_rsp.out_value, i_rsp.status);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("out_value", want.out_value, i_rsp.out_value);
                    compare_field("status", 32'(want.status), 32'(i_rsp.status));
                    compare_field("last_of_run", 32'(want.last_of_run),
                                  32'(i_rsp.last_of_run));
                    compare_field("queue_count", 32'(want.queue_count),
                                  32'(i_rsp.queue_count));
                end
            end
            if (i_req.valid && i_req.ready) begin
                predict_request(i_req.action, i_req.item_value);
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Top of the stack-to-queue transfer engine testbench: clock, reset, requests and
// receiver stalls, with the verdict taken from the checker's failure count.
// Depends on stq_pkg, stq_if, stack_to_queue_transfer_engine and stq_checker.
module tb;
    import stq_pkg::*;

    localparam int                     DEPTH            = DEPTH_DEFAULT;
    localparam logic [ACTION_BITS-1:0] ACT_SPARE_LO     = 3'd6;
    localparam logic [ACTION_BITS-1:0] ACT_SPARE_HI     = 3'd7;
    localparam int                     RANDOM_PER_PHASE = 20;
    localparam int                     DRAIN_CYCLES     = 20;

    logic i_clk;
    logic i_rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   n_requests;
    int   fail_count;
    int   pending;
    int   result_count;

    stq_req_if req ();
    stq_rsp_if rsp ();

    stack_to_queue_transfer_engine #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS_DEFAULT)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    stq_checker #(.DEPTH(DEPTH)) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (req),
        .i_rsp          (rsp),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("tb failed");
        $finish;
    end

    initial begin
        rsp.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic [ITEM_BITS-1:0] random_word();
        int roll;
        roll = $urandom_range(9);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        return $urandom;
    endfunction

    function automatic logic [ACTION_BITS-1:0] pick_action();
        int roll;
        roll = $urandom_range(99);
        if (roll < 24) return ACT_ENQ;
        if (roll < 38) return ACT_DEQ;
        if (roll < 62) return ACT_PUSH;
        if (roll < 76) return ACT_POP;
        if (roll < 84) return ACT_XFER;
        if (roll < 94) return ACT_DUMP;
        if (roll < 97) return ACT_SPARE_LO;
        return ACT_SPARE_HI;
    endfunction

    task automatic send_req(input logic [ACTION_BITS-1:0] act,
                            input logic [ITEM_BITS-1:0] word);
        while ($urandom_range(99) < send_idle_pct) begin
            req.valid <= 1'b0;
            @(negedge i_clk);
        end
        req.valid      <= 1'b1;
        req.action     <= act;
        req.item_value <= word;
        do @(posedge i_clk); while (!req.ready);
        @(negedge i_clk);
        n_requests++;
    endtask

    task automatic hold_until_drained();
        req.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    initial begin
        int i;
        int phase;
        i_rst_n        = 1'b0;
        req.valid      = 1'b0;
        req.action     = ACT_ENQ;
        req.item_value = '0;
        send_idle_pct  = 6;
        recv_idle_pct  = 76;
        n_requests     = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty structures first
        send_req(ACT_DEQ, 32'h1234_5678);
        send_req(ACT_POP, 32'hFFFF_FFFF);
        send_req(ACT_DUMP, '0);
        send_req(ACT_XFER, '0);
        send_req(ACT_ENQ, 32'h0000_0000);
        send_req(ACT_ENQ, 32'hFFFF_FFFF);
        send_req(ACT_PUSH, 32'hFFFF_FFFF);
        send_req(ACT_PUSH, 32'h0000_0000);
        send_req(ACT_PUSH, 32'h8000_0001);
        send_req(ACT_POP, '0);
        send_req(ACT_XFER, 32'h5555_5555);
        send_req(ACT_DUMP, '0);
        send_req(ACT_DEQ, '0);
        send_req(ACT_DUMP, '0);
        send_req(ACT_SPARE_LO, 32'hAAAA_AAAA);
        send_req(ACT_SPARE_HI, 32'h5555_5555);
        send_req(ACT_ENQ, 32'hA5A5_A5A5);
        repeat (5) send_req(ACT_DEQ, '0);
        send_req(ACT_DUMP, '0);

        // fill to capacity: full stack, full queue, overflowing transfer
        hold_until_drained();
        repeat (2) send_req(ACT_ENQ, random_word());
        repeat (DEPTH + 1) send_req(ACT_PUSH, random_word());
        send_req(ACT_POP, '0);
        send_req(ACT_PUSH, random_word());
        send_req(ACT_XFER, '0);
        send_req(ACT_ENQ, random_word());
        repeat (3) send_req(ACT_PUSH, random_word());
        send_req(ACT_XFER, '0);
        send_req(ACT_DUMP, '0);
        repeat (3) send_req(ACT_DEQ, '0);

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 6;
                    recv_idle_pct = 76;
                end
                1: begin
                    send_idle_pct = 76;
                    recv_idle_pct = 6;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (i = 0; i < RANDOM_PER_PHASE; i++) begin
                send_req(pick_action(), random_word());
            end
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("Covered %0d requests: empty and full cases, capacity fill, random mix",
                 n_requests);
        $display("under three idling patterns; %0d results checked", result_count);
        if (fail_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/stq_pkg.sv
sv/stq_if.sv
sv/stq_datapath.sv
sv/stq_ctrl.sv
sv/stack_to_queue_transfer_engine.sv
sv/stq_checker.sv
test/stq_checker.sv
test/tb.sv
